[hdl/dtp_pkg.sv]
`default_nettype none

package dtp_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_DOT     = 3'd2;
  localparam logic [2:0] PH_FRAC    = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;

  // Parser state carried between characters
  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] acc;
    logic        ovf;
  } state_t;

  // One step's result
  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

[hdl/dtp_step.sv]
`default_nettype none

// Next-state and result logic for one character
module dtp_step (
  input  wire logic [7:0]       char_code,
  input  wire logic [31:0]      max_tenths,
  input  wire dtp_pkg::state_t  cur,
  output dtp_pkg::state_t       nxt,
  output dtp_pkg::result_t      res
);

  logic        is_blank;
  logic        is_sep;
  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [3:0]  add_digit;
  logic [35:0] prod;
  logic        prod_over;
  logic [31:0] sat_acc;
  logic        sat_ovf;
  logic [31:0] fin_val;
  logic        fin_ovf;
  logic        use_sat;

  // Character classes
  assign is_blank = (char_code == dtp_pkg::CH_SPACE) || (char_code == dtp_pkg::CH_TAB);
  assign is_sep   = is_blank || (char_code == dtp_pkg::CH_NUL);
  assign is_digit = (char_code >= dtp_pkg::CH_ZERO) && (char_code <= dtp_pkg::CH_NINE);
  assign is_dot   = (char_code == dtp_pkg::CH_DOT);
  assign digit    = 4'(char_code - dtp_pkg::CH_ZERO);

  // acc * 10 + d, saturating; d is zero when closing on a separator
  assign add_digit = is_digit ? digit : 4'd0;
  assign prod      = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + {32'd0, add_digit};
  assign prod_over = (prod[35:32] != 4'd0);
  assign sat_acc   = prod_over ? dtp_pkg::ACC_MAX : prod[31:0];
  assign sat_ovf   = cur.ovf | prod_over;

  // Value at token end: integer and dot phases scale by ten first
  assign use_sat = (cur.phase == dtp_pkg::PH_INT) || (cur.phase == dtp_pkg::PH_DOT);
  assign fin_val = use_sat ? sat_acc : cur.acc;
  assign fin_ovf = use_sat ? sat_ovf : cur.ovf;

  always_comb begin
    nxt        = cur;
    res.emit   = 1'b0;
    res.value  = 32'd0;
    res.status = dtp_pkg::ST_OK;
    case (cur.phase)
      dtp_pkg::PH_IDLE: begin
        if (!is_blank) begin
          nxt.acc = 32'd0;
          nxt.ovf = 1'b0;
          if (char_code == dtp_pkg::CH_NUL) begin
            res.emit   = 1'b1;
            res.status = dtp_pkg::ST_INVALID;
          end else if (is_digit) begin
            nxt.acc   = {28'd0, digit};
            nxt.phase = dtp_pkg::PH_INT;
          end else if (is_dot) begin
            nxt.phase = dtp_pkg::PH_DOT;
          end else begin
            nxt.phase  = dtp_pkg::PH_DISCARD;
            res.emit   = 1'b1;
            res.status = dtp_pkg::ST_INVALID;
          end
        end
      end
      dtp_pkg::PH_INT, dtp_pkg::PH_DOT, dtp_pkg::PH_FRAC: begin
        if (is_digit) begin
          if (cur.phase != dtp_pkg::PH_FRAC) begin
            nxt.acc = sat_acc;
            nxt.ovf = sat_ovf;
          end
          if (cur.phase == dtp_pkg::PH_DOT) begin
            nxt.phase = dtp_pkg::PH_FRAC;
          end
        end else if (is_dot && (cur.phase == dtp_pkg::PH_INT)) begin
          nxt.phase = dtp_pkg::PH_DOT;
        end else if (is_sep) begin
          // token complete
          nxt.phase = dtp_pkg::PH_IDLE;
          nxt.acc   = 32'd0;
          nxt.ovf   = 1'b0;
          res.emit  = 1'b1;
          if (fin_ovf || (fin_val > max_tenths)) begin
            res.status = dtp_pkg::ST_TOO_LARGE;
          end else begin
            res.value = fin_val;
          end
        end else begin
          nxt.phase  = dtp_pkg::PH_DISCARD;
          nxt.acc    = 32'd0;
          nxt.ovf    = 1'b0;
          res.emit   = 1'b1;
          res.status = dtp_pkg::ST_INVALID;
        end
      end
      default: begin
        // discarding up to the next separator
        if (is_sep) begin
          nxt.phase = dtp_pkg::PH_IDLE;
          nxt.acc   = 32'd0;
          nxt.ovf   = 1'b0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/decimal_tenths_parser.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------
// input    | in_valid / in_ready  | char_code[7:0]
// output   | out_valid / out_ready| value_tenths[31:0], status[1:0]
// config   | cfg_valid / cfg_ready| cfg_data[31:0] (max_tenths)
//
// One character per clock unless a result meets a stalled output; a character
// is held in the input register and any result it has in the output register.
// The per-character work is one multiply-by-ten add and a compare against
// max_tenths, done between the input register and the state/output registers.
// Synchronous active-high reset clears the parse state and sets max_tenths to
// all ones. A stalled output holds the input register only when it has a
// result to pass on; characters without a result still flow.
`default_nettype none

module decimal_tenths_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value_tenths,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic              chr_valid;
  logic [7:0]        chr;
  logic [31:0]       max_tenths;
  dtp_pkg::state_t   st;
  dtp_pkg::state_t   st_next;
  dtp_pkg::result_t  res;
  logic              slot_free;
  logic              advance;

  dtp_step u_step (
    .char_code  (chr),
    .max_tenths (max_tenths),
    .cur        (st),
    .nxt        (st_next),
    .res        (res)
  );

  // Handshake: the character moves on unless its result meets a full output
  assign slot_free = !out_valid || out_ready;
  assign advance   = chr_valid && (slot_free || !res.emit);
  assign in_ready  = !chr_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tenths <= dtp_pkg::ACC_MAX;
    end else if (cfg_valid) begin
      max_tenths <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (in_ready) begin
      chr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chr <= char_code;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= dtp_pkg::PH_IDLE;
      st.acc   <= 32'd0;
      st.ovf   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      value_tenths <= res.value;
      status       <= res.status;
    end
  end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 250;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] value_tenths;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  decimal_tenths_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_tenths (value_tenths),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Parser mirror state and the configured limit
  logic [2:0]  tenths_ph;
  logic [31:0] tenths_acc;
  logic        tenths_ovf;
  logic [31:0] max_tenths_m;

  dtp_pkg::result_t pending_results[$];

  int errors;
  int chars_seen;
  int n_ok;
  int n_invalid;
  int n_large;
  int cfg_writes;
  int cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int hold_left;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= dtp_pkg::CH_ZERO) && (c <= dtp_pkg::CH_NINE);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == dtp_pkg::CH_NUL) || (c == dtp_pkg::CH_SPACE) || (c == dtp_pkg::CH_TAB);
  endfunction

  // acc = acc * 10 + d, held at all ones on overflow
  function automatic void shift_digit(input logic [3:0] d);
    logic [35:0] t;
    t = 36'(tenths_acc) * 36'd10 + 36'(d);
    if (t > 36'(dtp_pkg::ACC_MAX)) begin
      tenths_acc = dtp_pkg::ACC_MAX;
      tenths_ovf = 1'b1;
    end else begin
      tenths_acc = t[31:0];
    end
  endfunction

  function automatic dtp_pkg::result_t close_token();
    dtp_pkg::result_t r;
    r.emit = 1'b1;
    if (tenths_ovf || (tenths_acc > max_tenths_m)) begin
      r.value  = '0;
      r.status = dtp_pkg::ST_TOO_LARGE;
    end else begin
      r.value  = tenths_acc;
      r.status = dtp_pkg::ST_OK;
    end
    tenths_ph  = dtp_pkg::PH_IDLE;
    tenths_acc = '0;
    tenths_ovf = 1'b0;
    return r;
  endfunction

  function automatic dtp_pkg::result_t reject();
    dtp_pkg::result_t r;
    r.emit     = 1'b1;
    r.value    = '0;
    r.status   = dtp_pkg::ST_INVALID;
    tenths_ph  = dtp_pkg::PH_DISCARD;
    tenths_acc = '0;
    tenths_ovf = 1'b0;
    return r;
  endfunction

  // Advance the mirror by one character; emit set when a result is due
  function automatic dtp_pkg::result_t parse_char(input logic [7:0] c);
    dtp_pkg::result_t r;
    r = '0;
    case (tenths_ph)
      dtp_pkg::PH_IDLE: begin
        if ((c != dtp_pkg::CH_SPACE) && (c != dtp_pkg::CH_TAB)) begin
          tenths_acc = '0;
          tenths_ovf = 1'b0;
          if (c == dtp_pkg::CH_NUL) begin
            r.emit   = 1'b1;
            r.status = dtp_pkg::ST_INVALID;
          end else if (is_digit(c)) begin
            tenths_acc = 32'(c - dtp_pkg::CH_ZERO);
            tenths_ph  = dtp_pkg::PH_INT;
          end else if (c == dtp_pkg::CH_DOT) begin
            tenths_ph = dtp_pkg::PH_DOT;
          end else begin
            r = reject();
          end
        end
      end
      dtp_pkg::PH_INT: begin
        if (is_digit(c)) begin
          shift_digit(4'(c - dtp_pkg::CH_ZERO));
        end else if (c == dtp_pkg::CH_DOT) begin
          tenths_ph = dtp_pkg::PH_DOT;
        end else if (is_sep(c)) begin
          shift_digit(4'd0);
          r = close_token();
        end else begin
          r = reject();
        end
      end
      dtp_pkg::PH_DOT: begin
        if (is_digit(c)) begin
          shift_digit(4'(c - dtp_pkg::CH_ZERO));
          tenths_ph = dtp_pkg::PH_FRAC;
        end else if (is_sep(c)) begin
          shift_digit(4'd0);
          r = close_token();
        end else begin
          r = reject();
        end
      end
      dtp_pkg::PH_FRAC: begin
        // extra fraction digits are dropped
        if (!is_digit(c)) begin
          if (is_sep(c)) r = close_token();
          else r = reject();
        end
      end
      default: begin
        if (is_sep(c)) begin
          tenths_ph  = dtp_pkg::PH_IDLE;
          tenths_acc = '0;
          tenths_ovf = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input monitor: predict on every accepted character transaction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      dtp_pkg::result_t r;
      chars_seen++;
      r = parse_char(char_code);
      if (r.emit) pending_results.push_back(r);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      dtp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'(dtp_pkg::ST_OK));
      end else begin
        want = pending_results.pop_front();
        if (value_tenths !== want.value)
          report_mismatch("value_tenths", value_tenths, want.value);
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        case (want.status)
          dtp_pkg::ST_OK:      n_ok++;
          dtp_pkg::ST_INVALID: n_invalid++;
          default:             n_large++;
        endcase
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("tb_top NOT OK");
    $finish;
  end

  // One character transaction; valid stays high into the next call unless it idles
  task automatic send_char(input logic [7:0] c);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      if (!idled) in_valid <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stop sending and wait for every expected result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_tenths(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    max_tenths_m  = v;
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(2))
      0:       return dtp_pkg::CH_SPACE;
      1:       return dtp_pkg::CH_TAB;
      default: return dtp_pkg::CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(dtp_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  // One random token: mostly well formed, some broken, some noise
  task automatic send_token();
    int kind;
    int ndig;
    int nfrac;
    bit dot;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)));
      send_char(pick_sep());
    end else if (kind < 20) begin
      repeat ($urandom_range(3, 1)) send_char(pick_digit());
      if ($urandom_range(1)) begin
        // second dot
        send_char(dtp_pkg::CH_DOT);
        if ($urandom_range(1)) send_char(pick_digit());
        send_char(dtp_pkg::CH_DOT);
      end else begin
        do c = 8'($urandom_range(255));
        while (is_digit(c) || is_sep(c) || (c == dtp_pkg::CH_DOT));
        send_char(c);
      end
      // trailing junk is discarded up to the separator
      repeat ($urandom_range(3)) begin
        do c = 8'($urandom_range(255));
        while (is_sep(c));
        send_char(c);
      end
      send_char(pick_sep());
    end else begin
      repeat ($urandom_range(2))
        send_char($urandom_range(1) ? dtp_pkg::CH_SPACE : dtp_pkg::CH_TAB);
      ndig  = ($urandom_range(9) == 0) ? $urandom_range(11, 9) : $urandom_range(4);
      dot   = (ndig == 0) || $urandom_range(1);
      nfrac = dot ? $urandom_range(3) : 0;
      repeat (ndig) send_char(pick_digit());
      if (dot) send_char(dtp_pkg::CH_DOT);
      repeat (nfrac) send_char(pick_digit());
      send_char(pick_sep());
    end
  endtask

  // Separators, fraction handling, lone dot, empty line, bad characters, overflow
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_text(" \t9.87");
    send_char(dtp_pkg::CH_NUL);
    send_text(". ");
    send_char(dtp_pkg::CH_NUL);
    send_text("1.2.3 ");
    send_char(8'hFF);
    send_text("ab ");
    send_text("7x\t");
    send_text("42949672950 ");
    send_text("0 ");
    drain();
  endtask

  // Limit at both ends of its range
  task automatic test_max_extremes();
    write_max_tenths(32'd0);
    send_text("0 .0 0.1 ");
    write_max_tenths(dtp_pkg::ACC_MAX);
    send_text("429496729.5 429496729.6 ");
    drain();
  endtask

  task automatic test_random(input int n, input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = chars_seen;
    while (chars_seen - start < n) send_token();
    drain();
  endtask

  // Receiver held off while the sender keeps offering; input must stall
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = HOLD_CYCLES;
    repeat (30) send_text("5 ");
    drain();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_code    = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    tenths_ph    = dtp_pkg::PH_IDLE;
    tenths_acc   = '0;
    tenths_ovf   = 1'b0;
    max_tenths_m = dtp_pkg::ACC_MAX;
    errors       = 0;
    chars_seen   = 0;
    n_ok         = 0;
    n_invalid    = 0;
    n_large      = 0;
    cfg_writes   = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_req     = 0;
    hold_left    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_max_extremes();
    write_max_tenths(32'd1234);
    test_random(575, 7, 75);
    write_max_tenths(32'($urandom_range(200000)));
    test_random(575, 75, 7);
    write_max_tenths(dtp_pkg::ACC_MAX);
    test_backpressure();
    write_max_tenths(32'($urandom_range(200000)));
    test_random(575, 0, 0);
    drain();

    $display("Covered %0d characters, %0d results: %0d ok, %0d invalid, %0d too large",
             chars_seen, n_ok + n_invalid + n_large, n_ok, n_invalid, n_large);
    $display("%0d limit writes incl. zero and all ones; one %0d-cycle receiver hold-off",
             cfg_writes, HOLD_CYCLES);
    if ((errors == 0) && (pending_results.size() == 0)) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
